// ===== hw/rtl/msqrt_pkg.sv =====
// Package for the modular square root block: command/status types and constants.
// Used by msqrt_ctrl, msqrt_dp and modular_square_root. No dependencies.
package msqrt_pkg;

  localparam int unsigned DATA_W = 16;

  typedef enum logic [2:0] {
    DP_NOP   = 3'd0,
    DP_LOAD  = 3'd1,   // latch operand, start reduction a mod n
    DP_POW   = 3'd2,   // start base^exp mod n
    DP_MULT  = 3'd3,   // start x*y mod n
    DP_SETX  = 3'd4    // hold value for later
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/msqrt_mulmod.sv =====
// Sequential modular multiplier: x*y mod n by shift-and-add, one bit of y per cycle.
// Depends on nothing; used by msqrt_dp.
module msqrt_mulmod #(
  parameter int unsigned W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] n,
  output logic         busy,
  output logic [W-1:0] p
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0] acc_r, acc_nxt, x_r, y_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [W+1:0] dbl, add;
  logic [W-1:0] dred;

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    // acc = 2*acc (+x) mod n, msb of y first; x<n, acc<n.
    dbl = {1'b0, acc_r, 1'b0};
    dred = (dbl >= {2'b00, n}) ? W'(dbl - {2'b00, n}) : W'(dbl);
    add = {2'b00, dred} + (y_r[W-1] ? {2'b00, x_r} : '0);
    if (start) begin
      acc_nxt = '0;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (add >= {2'b00, n}) ? W'(add - {2'b00, n}) : W'(add);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    if (start) begin
      x_r <= x;
      y_r <= y;
    end else if (busy_r) begin
      y_r <= {y_r[W-2:0], 1'b0};
    end
  end

  assign busy = busy_r;
  assign p = acc_r;
endmodule

// ===== hw/rtl/msqrt_dp.sv =====
// Datapath: operand reduction, square-and-multiply exponentiation and plain x*y mod n over msqrt_mulmod.
// Depends on msqrt_pkg and msqrt_mulmod.
module msqrt_dp #(
  parameter int unsigned W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  msqrt_pkg::dp_cmd_t  cmd,
  input  logic [W-1:0]        arg_a,
  input  logic [W-1:0]        arg_b,
  input  logic [W-1:0]        n,
  output msqrt_pkg::dp_status_t st,
  output logic [W-1:0]        res
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_PSQ  = 5'b00100,
    S_PML  = 5'b01000,
    S_MUL  = 5'b10000
  } dps_t;

  localparam int unsigned CW = $clog2(W + 1);
  dps_t s_r, s_nxt;
  logic [W-1:0] base_r, e_r, res_r, rem_r;
  logic [W-1:0] base_nxt, e_nxt, res_nxt, rem_nxt;
  logic [CW-1:0] rc_r, rc_nxt;
  logic [W-1:0] ax_r, ax_nxt;
  logic m_start, m_busy;
  logic [W-1:0] m_x, m_y, m_p;
  logic [W:0] rsh;

  msqrt_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .x(m_x), .y(m_y), .n(n),
    .busy(m_busy), .p(m_p)
  );

  always_comb begin
    s_nxt = s_r; base_nxt = base_r; e_nxt = e_r; res_nxt = res_r;
    rem_nxt = rem_r; rc_nxt = rc_r; ax_nxt = ax_r;
    m_start = 1'b0; m_x = base_r; m_y = base_r;
    rsh = {rem_r, ax_r[W-1]};
    unique case (s_r)
      S_IDLE: begin
        unique case (cmd)
          msqrt_pkg::DP_LOAD: begin
            // restoring reduction of arg_a by n, one bit per cycle
            ax_nxt = arg_a; rem_nxt = '0; rc_nxt = CW'(W); s_nxt = S_RED;
          end
          msqrt_pkg::DP_POW: begin
            base_nxt = arg_a; e_nxt = arg_b; res_nxt = W'(1); s_nxt = S_PSQ;
          end
          msqrt_pkg::DP_MULT: begin
            m_start = 1'b1; m_x = arg_a; m_y = arg_b; s_nxt = S_MUL;
          end
          msqrt_pkg::DP_SETX: res_nxt = arg_a;
          default: ;
        endcase
      end
      S_RED: begin
        rem_nxt = (rsh >= {1'b0, n}) ? W'(rsh - {1'b0, n}) : W'(rsh);
        ax_nxt = {ax_r[W-2:0], 1'b0};
        rc_nxt = rc_r - 1'b1;
        if (rc_r == CW'(1)) begin
          res_nxt = (rsh >= {1'b0, n}) ? W'(rsh - {1'b0, n}) : W'(rsh);
          s_nxt = S_IDLE;
        end
      end
      S_PSQ: begin
        // low exponent bit first: multiply into res when set, else square base;
        // ax marks a square in flight
        if (e_r == '0) s_nxt = S_IDLE;
        else if (e_r[0]) begin
          m_start = 1'b1; m_x = res_r; m_y = base_r; ax_nxt = '0; s_nxt = S_PML;
        end else begin
          m_start = 1'b1; ax_nxt = '1; s_nxt = S_PML;
        end
      end
      S_PML: begin
        if (!m_busy) begin
          if (ax_r == '1) begin
            base_nxt = m_p; e_nxt = {1'b0, e_r[W-1:1]};
          end else begin
            // result multiply done; drop the bit, square next
            res_nxt = m_p; e_nxt = {e_r[W-1:1], 1'b0};
          end
          s_nxt = S_PSQ;
        end
      end
      S_MUL: begin
        if (!m_busy) begin
          res_nxt = m_p; s_nxt = S_IDLE;
        end
      end
      default: s_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= S_IDLE;
      ax_r <= '0;
    end else begin
      s_r <= s_nxt;
      ax_r <= ax_nxt;
    end
    base_r <= base_nxt; e_r <= e_nxt; res_r <= res_nxt;
    rem_r <= rem_nxt; rc_r <= rc_nxt;
  end

  assign st.busy = (s_r != S_IDLE);
  assign res = res_r;

`ifndef SYNTHESIS
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd != msqrt_pkg::DP_NOP) |-> (s_r == S_IDLE)) else $error("dp cmd while busy");
  a_res_lt_n: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(st.busy) && n > W'(1) |-> res_r < n) else $error("dp result not reduced");
  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    m_start |=> m_busy) else $error("mulmod did not start");
`endif
endmodule

// ===== hw/rtl/msqrt_ctrl.sv =====
// Controller: sequences Euler test, 3 mod 4 shortcut, nonresidue search and halving loop on msqrt_dp.
// Depends on msqrt_pkg.
module msqrt_ctrl #(
  parameter int unsigned W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [W-1:0]          n,
  input  msqrt_pkg::dp_status_t st,
  input  logic [W-1:0]          dres,
  output msqrt_pkg::dp_cmd_t    cmd,
  output logic [W-1:0]          arg_a,
  output logic [W-1:0]          arg_b,
  output logic                  done,
  output logic [W-1:0]          root,
  output logic                  found
);
  typedef enum logic [13:0] {
    C_IDLE  = 14'b00000000000001,
    C_RED   = 14'b00000000000010,
    C_EUL   = 14'b00000000000100,
    C_P34   = 14'b00000000001000,
    C_SRCH  = 14'b00000000010000,
    C_HA    = 14'b00000000100000,
    C_HB    = 14'b00000001000000,
    C_HM    = 14'b00000010000000,
    C_FA    = 14'b00000100000000,
    C_FB    = 14'b00001000000000,
    C_FM    = 14'b00010000000000,
    C_OUT   = 14'b00100000000000,
    C_WAIT  = 14'b01000000000000,
    C_HCHK  = 14'b10000000000000
  } cst_t;

  cst_t s_r, s_nxt, ret_r, ret_nxt;
  logic [W-1:0] a_r, a_nxt, b_r, b_nxt, i_r, i_nxt, k_r, k_nxt, t_r, t_nxt;
  logic [W-1:0] x_r, x_nxt;
  logic ok_r, ok_nxt;
  logic [W-1:0] half, n1;

  assign half = {1'b0, n[W-1:1]};
  assign n1 = n - 1'b1;

  always_comb begin
    s_nxt = s_r; ret_nxt = ret_r; a_nxt = a_r; b_nxt = b_r; i_nxt = i_r;
    k_nxt = k_r; t_nxt = t_r; x_nxt = x_r; ok_nxt = ok_r;
    cmd = msqrt_pkg::DP_NOP; arg_a = a_r; arg_b = half;
    done = 1'b0;
    unique case (s_r)
      C_IDLE: if (start) begin
        ok_nxt = 1'b0; x_nxt = '0;
        if (n < W'(2)) s_nxt = C_OUT;
        else begin
          cmd = msqrt_pkg::DP_LOAD; ret_nxt = C_RED; s_nxt = C_WAIT;
        end
      end
      C_WAIT: if (!st.busy) s_nxt = ret_r;
      C_RED: begin
        a_nxt = dres;
        if (n == W'(2)) begin
          // modulus two: the root is the operand's low bit
          x_nxt = dres; ok_nxt = 1'b1; s_nxt = C_OUT;
        end else if (dres == '0) begin
          ok_nxt = 1'b1; s_nxt = C_OUT;
        end else begin
          cmd = msqrt_pkg::DP_POW; arg_a = dres; arg_b = half;
          ret_nxt = C_EUL; s_nxt = C_WAIT;
        end
      end
      C_EUL: begin
        if (dres != W'(1)) s_nxt = C_OUT;
        else if (n[1:0] == 2'b11) begin
          ok_nxt = 1'b1;
          cmd = msqrt_pkg::DP_POW; arg_b = W'(({1'b0, n} + 1'b1) >> 2);
          ret_nxt = C_P34; s_nxt = C_WAIT;
        end else begin
          b_nxt = W'(1);
          cmd = msqrt_pkg::DP_POW; arg_a = W'(1); arg_b = half;
          ret_nxt = C_SRCH; s_nxt = C_WAIT;
        end
      end
      C_P34: begin
        x_nxt = dres; s_nxt = C_FM;
        cmd = msqrt_pkg::DP_SETX; arg_a = dres;
      end
      C_SRCH: begin
        if (dres != W'(1)) begin
          ok_nxt = 1'b1; i_nxt = half; k_nxt = '0;
          s_nxt = half[0] ? C_FA : C_HA;
        end else if (b_r + 1'b1 >= n) begin
          s_nxt = C_OUT;
        end else begin
          b_nxt = b_r + 1'b1;
          cmd = msqrt_pkg::DP_POW; arg_a = b_r + 1'b1; arg_b = half;
          ret_nxt = C_SRCH; s_nxt = C_WAIT;
        end
      end
      C_HA: begin
        i_nxt = {1'b0, i_r[W-1:1]}; k_nxt = {1'b0, k_r[W-1:1]};
        cmd = msqrt_pkg::DP_POW; arg_a = a_r; arg_b = {1'b0, i_r[W-1:1]};
        ret_nxt = C_HB; s_nxt = C_WAIT;
      end
      C_HB: begin
        t_nxt = dres;
        cmd = msqrt_pkg::DP_POW; arg_a = b_r; arg_b = k_r;
        ret_nxt = C_HM; s_nxt = C_WAIT;
      end
      C_HM: begin
        cmd = msqrt_pkg::DP_MULT; arg_a = t_r; arg_b = dres;
        ret_nxt = C_HCHK; s_nxt = C_WAIT;
      end
      C_HCHK: begin
        if (dres == n1) k_nxt = W'({1'b0, k_r} + {1'b0, half});
        s_nxt = i_r[0] ? C_FA : C_HA;
      end
      C_FA: begin
        cmd = msqrt_pkg::DP_POW; arg_a = a_r;
        arg_b = W'(({1'b0, i_r} + 1'b1) >> 1);
        ret_nxt = C_FB; s_nxt = C_WAIT;
      end
      C_FB: begin
        t_nxt = dres;
        cmd = msqrt_pkg::DP_POW; arg_a = b_r; arg_b = {1'b0, k_r[W-1:1]};
        ret_nxt = C_FM; s_nxt = C_WAIT;
      end
      C_FM: begin
        if (ret_r == C_FM) begin
          cmd = msqrt_pkg::DP_MULT; arg_a = t_r; arg_b = dres;
          ret_nxt = C_OUT; s_nxt = C_WAIT;
        end else begin
          x_nxt = dres; ret_nxt = C_FM;
          s_nxt = C_OUT;
        end
      end
      C_OUT: begin
        if (ret_r == C_OUT) x_nxt = dres;
        ret_nxt = C_IDLE;
        s_nxt = C_IDLE;
        done = 1'b1;
      end
      default: s_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= C_IDLE;
      ret_r <= C_IDLE;
    end else begin
      s_r <= s_nxt;
      ret_r <= ret_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; i_r <= i_nxt; k_r <= k_nxt; t_r <= t_nxt;
    x_r <= x_nxt; ok_r <= ok_nxt;
  end

  logic [W-1:0] xf;
  logic [W:0] twf;
  always_comb begin
    xf = (s_r == C_OUT && ret_r == C_OUT) ? dres : x_r;
    twf = {xf, 1'b0};
    if (!ok_r) root = '0;
    else if (n > W'(2) && twf > {1'b0, n}) root = n - xf;
    else root = xf;
  end
  assign found = ok_r;

`ifndef SYNTHESIS
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done repeated");
  a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    done && !found |-> root == '0) else $error("root set without found");
  a_wait_ret: assert property (@(posedge clk) disable iff (!rst_n)
    s_r == C_WAIT |-> ret_r != C_WAIT) else $error("bad return state");
`endif
endmodule

// ===== hw/rtl/modular_square_root.sv =====
// Top level of the modular square root block: stream ports, config register, output reg.
// Depends on msqrt_pkg, msqrt_ctrl, msqrt_dp.
//
//  channel | direction | tdata fields (low bit up)       | tuser
//  in_     | slave     | operand[15:0]                   | -
//  out_    | master    | root[15:0], found[16], pad zero | -
//  cfg_    | write     | modulus[15:0]                   | -
//
// Operation: one item at a time; each modular multiply runs on the single shift-add
// multiplier (W is MOD_WIDTH, at least 16), an exponentiation takes up to 2*W-1
// multiplies, so an item costs least for 3 mod 4 moduli and far more when the
// nonresidue search and halving loop run.
// Reset: synchronous active-low rst_n; modulus returns to 2, all control idles.
// Stalls: a result waits in the output register; the next word is accepted meanwhile.
module modular_square_root #(
  parameter int unsigned MOD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // operand[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // root[15:0], found[16], zeros[23:17]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data // modulus[15:0]
);
  localparam int unsigned W = (MOD_WIDTH > 16) ? MOD_WIDTH : 16;

  logic [W-1:0] n_r, n_nxt;
  logic busy_r, busy_nxt;
  logic pend_r, pend_nxt;
  logic [15:0] opnd_r;
  logic ov_r, ov_nxt;
  logic [16:0] od_r;
  logic start, done, found;
  logic [W-1:0] root, dres, arg_a, arg_b;
  msqrt_pkg::dp_cmd_t cmd;
  msqrt_pkg::dp_status_t st;
  logic in_acc;

  // Accept a word when no word is held waiting to start.
  assign in_tready = !pend_r;
  assign in_acc = in_tvalid && in_tready;
  // Start held word once the engine is idle and the prior result has a slot.
  assign start = pend_r && !busy_r && (!ov_r || out_tready);

  always_comb begin
    n_nxt = n_r;
    if (cfg_wr_en) begin
      n_nxt = W'(cfg_wr_data & 16'(({17'd1} << (MOD_WIDTH > 16 ? 16 : MOD_WIDTH)) - 1));
    end
    pend_nxt = pend_r;
    if (start) pend_nxt = 1'b0;
    if (in_acc) pend_nxt = 1'b1;
    busy_nxt = busy_r;
    if (start) busy_nxt = 1'b1;
    if (done) busy_nxt = 1'b0;
    ov_nxt = ov_r;
    if (out_tvalid && out_tready) ov_nxt = 1'b0;
    if (done) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= W'(2);
      pend_r <= 1'b0;
      busy_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      n_r <= n_nxt;
      pend_r <= pend_nxt;
      busy_r <= busy_nxt;
      ov_r <= ov_nxt;
    end
    if (in_acc) opnd_r <= in_tdata;
    if (done) od_r <= {found, root[15:0]};
  end

  msqrt_ctrl #(.W(W)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .n(n_r), .st(st), .dres(dres),
    .cmd(cmd), .arg_a(arg_a), .arg_b(arg_b), .done(done), .root(root), .found(found)
  );

  msqrt_dp #(.W(W)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .arg_a((start) ? W'(opnd_r) : arg_a), .arg_b(arg_b), .n(n_r),
    .st(st), .res(dres)
  );

  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, od_r};

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !ov_r || out_tready) else $error("result overwritten");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("start while busy");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy_r) else $error("done without item");
`endif
endmodule
